// ----- rtl/jnd_pkg.sv -----
// jnd_pkg: shared types, widths and codes for the joystick normalize/deadband block.
// No dependencies. Used by every module under rtl/.
package jnd_pkg;

   // default parameter values
   localparam int AXIS_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF = 14;

   // fixed field widths
   localparam int UB_W     = 9;    // upper bound register
   localparam int DIV_W    = 10;   // lower magnitude register, widest divisor
   localparam int DEAD_W   = 15;   // deadband radius
   localparam int OUT_W    = 16;   // result fields
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_BOUND_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_MAG_X   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_BOUND_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_MAG_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_Y      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_RADIUS   = 3'd6;

   // reset values
   localparam logic [UB_W-1:0]  UB_RESET = 9'd511;
   localparam logic [DIV_W-1:0] LM_RESET = 10'd512;

   // how an axis gets its magnitude
   typedef enum logic [1:0] {
      KIND_ZERO,   // zero reading
      KIND_FULL,   // zero divisor or quotient at or past one
      KIND_DIV     // fractional quotient, long division needed
   } kind_type;

   typedef struct packed {
      logic [UB_W-1:0]   upper_bound_x;
      logic [DIV_W-1:0]  lower_mag_x;
      logic [UB_W-1:0]   upper_bound_y;
      logic [DIV_W-1:0]  lower_mag_y;
      logic              invert_x;
      logic              invert_y;
      logic [DEAD_W-1:0] dead_radius;
   } cfg_type;

   // one classified axis; rem holds the magnitude, below the divisor for KIND_DIV
   typedef struct packed {
      logic             neg;
      kind_type         kind;
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] dv;
   } axis_item_type;

   typedef struct packed {
      axis_item_type x;
      axis_item_type y;
   } item_type;

endpackage

// ----- rtl/jnd_csr.sv -----
// jnd_csr: configuration register file, written through the csr_ port.
// Depends on jnd_pkg.
module jnd_csr
   import jnd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // decode the written register, indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_UPPER_BOUND_X: cfg_in.upper_bound_x = csr_wdata[UB_W-1:0];
            REG_LOWER_MAG_X:   cfg_in.lower_mag_x   = csr_wdata[DIV_W-1:0];
            REG_UPPER_BOUND_Y: cfg_in.upper_bound_y = csr_wdata[UB_W-1:0];
            REG_LOWER_MAG_Y:   cfg_in.lower_mag_y   = csr_wdata[DIV_W-1:0];
            REG_INVERT_X:      cfg_in.invert_x      = csr_wdata[0];
            REG_INVERT_Y:      cfg_in.invert_y      = csr_wdata[0];
            REG_DEAD_RADIUS:   cfg_in.dead_radius   = csr_wdata[DEAD_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_bound_x <= UB_RESET;
         cfg_ff.lower_mag_x   <= LM_RESET;
         cfg_ff.upper_bound_y <= UB_RESET;
         cfg_ff.lower_mag_y   <= LM_RESET;
         cfg_ff.invert_x      <= 1'b0;
         cfg_ff.invert_y      <= 1'b0;
         cfg_ff.dead_radius   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/jnd_front.sv -----
// jnd_front: takes raw samples and classifies each axis (sign, magnitude, divisor,
// zero / full scale / divide). Depends on jnd_pkg; feeds jnd_queue.
module jnd_front
   import jnd_pkg::*;
#(
   parameter int AXIS_BITS = AXIS_BITS_DEF
) (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [AXIS_BITS-1:0] req_raw_x,
   input  logic signed [AXIS_BITS-1:0] req_raw_y,
   input  cfg_type                     cfg,
   input  logic                        q_full,
   output logic                        push,
   output item_type                    push_item
);

   localparam int CMP_W = (AXIS_BITS > DIV_W) ? AXIS_BITS : DIV_W;

   // sign, magnitude and divisor of one axis, and which path it takes
   function automatic axis_item_type classify(input logic [AXIS_BITS-1:0] raw,
                                              input logic [UB_W-1:0]      ub,
                                              input logic [DIV_W-1:0]     lm);
      logic                 is_neg;
      logic [AXIS_BITS-1:0] mag;
      logic [CMP_W-1:0]     mag_e;
      logic [CMP_W-1:0]     div_e;
      axis_item_type        it;
      is_neg = raw[AXIS_BITS-1];
      mag    = is_neg ? (~raw + 1'b1) : raw;
      mag_e  = CMP_W'(mag);
      it.neg = is_neg;
      it.dv  = is_neg ? lm : DIV_W'(ub);
      div_e  = CMP_W'(it.dv);
      it.rem = mag_e[DIV_W-1:0];
      priority if (mag == '0) begin
         it.kind = KIND_ZERO;
      end else if (it.dv == '0 || mag_e >= div_e) begin
         it.kind = KIND_FULL;
      end else begin
         it.kind = KIND_DIV;
      end
      return it;
   endfunction

   // stall only on a full queue
   assign req_stall   = q_full;
   assign push        = req_valid && !q_full;
   assign push_item.x = classify(req_raw_x, cfg.upper_bound_x, cfg.lower_mag_x);
   assign push_item.y = classify(req_raw_y, cfg.upper_bound_y, cfg.lower_mag_y);

endmodule

// ----- rtl/jnd_queue.sv -----
// jnd_queue: short request queue between the classifying front and the divide back.
// Depends on jnd_pkg.
module jnd_queue
   import jnd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     rd_valid,
   output item_type rd_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == DEPTH_CNT);
   assign rd_valid = (cnt_ff != '0);
   assign rd_item  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_CNT)
      else $error("queue count past depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("push did not raise count");

endmodule

// ----- rtl/jnd_back.sv -----
// jnd_back: restoring divide pipeline (one quotient bit per stage), clamp and
// invert, radius-squared deadband and result register. Depends on jnd_pkg.
module jnd_back
   import jnd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    q_valid,
   input  item_type                q_item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_out_x,
   output logic signed [OUT_W-1:0] rsp_out_y
);

   localparam int MAG_W  = FRAC_BITS + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DSQ_W  = 2 * DEAD_W;
   localparam int SUM_W  = ((SQ_W + 1) > DSQ_W) ? (SQ_W + 1) : DSQ_W;
   localparam int NEG_W  = ((MAG_W + 1) > OUT_W) ? (MAG_W + 1) : OUT_W;
   localparam logic [MAG_W-1:0] ONE_MAG = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic                 neg;
      kind_type             kind;
      logic [DIV_W-1:0]     rem;
      logic [DIV_W-1:0]     dv;
      logic [FRAC_BITS-1:0] quot;
   } lane_type;

   // one bit of restoring division
   function automatic lane_type div_step(input lane_type l);
      logic [DIV_W:0] sh;
      lane_type       n;
      n  = l;
      sh = {l.rem, 1'b0};
      if (sh >= {1'b0, l.dv}) begin
         n.rem  = DIV_W'(sh - {1'b0, l.dv});
         n.quot = {l.quot[FRAC_BITS-2:0], 1'b1};
      end else begin
         n.rem  = sh[DIV_W-1:0];
         n.quot = {l.quot[FRAC_BITS-2:0], 1'b0};
      end
      return n;
   endfunction

   function automatic lane_type to_lane(input axis_item_type a);
      lane_type l;
      l.neg  = a.neg;
      l.kind = a.kind;
      l.rem  = a.rem;
      l.dv   = a.dv;
      l.quot = '0;
      return l;
   endfunction

   // clamped magnitude of a finished lane
   function automatic logic [MAG_W-1:0] mag_of(input lane_type l);
      logic [MAG_W-1:0] m;
      unique case (l.kind)
         KIND_ZERO: m = '0;
         KIND_FULL: m = ONE_MAG;
         KIND_DIV:  m = {1'b0, l.quot};
         default:   m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [OUT_W-1:0] to_field(input logic [MAG_W-1:0] m,
                                                 input logic neg);
      logic [NEG_W-1:0] v;
      v = NEG_W'(m);
      if (neg) begin
         v = -v;
      end
      return v[OUT_W-1:0];
   endfunction

   // whole pipe moves when the result register is free or being taken
   logic adv;

   lane_type         lx_ff [0:FRAC_BITS];
   lane_type         ly_ff [0:FRAC_BITS];
   lane_type         lx_in [0:FRAC_BITS];
   lane_type         ly_in [0:FRAC_BITS];
   logic [FRAC_BITS:0] vld_ff, vld_in;

   logic             mvld_ff;
   logic [MAG_W-1:0] magx_ff, magx_in, magy_ff, magy_in;
   logic             negx_ff, negx_in, negy_ff, negy_in;
   logic [SQ_W-1:0]  sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [DSQ_W-1:0] dead_sq_ff, dead_sq_in;

   logic             rsp_valid_ff;
   logic [OUT_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [SUM_W-1:0] r2;
   logic             inside_dead;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = adv && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;

   // divide stages
   always_comb begin
      lx_in[0] = to_lane(q_item.x);
      ly_in[0] = to_lane(q_item.y);
      for (int k = 0; k < FRAC_BITS; k++) begin
         lx_in[k+1] = div_step(lx_ff[k]);
         ly_in[k+1] = div_step(ly_ff[k]);
      end
      vld_in = {vld_ff[FRAC_BITS-1:0], pop};
   end

   // clamp, sign after invert, squares
   always_comb begin
      magx_in = mag_of(lx_ff[FRAC_BITS]);
      magy_in = mag_of(ly_ff[FRAC_BITS]);
      negx_in = (magx_in != '0) && (lx_ff[FRAC_BITS].neg ^ cfg.invert_x);
      negy_in = (magy_in != '0) && (ly_ff[FRAC_BITS].neg ^ cfg.invert_y);
      sqx_in  = SQ_W'(magx_in) * SQ_W'(magx_in);
      sqy_in  = SQ_W'(magy_in) * SQ_W'(magy_in);
      dead_sq_in = DSQ_W'(cfg.dead_radius) * DSQ_W'(cfg.dead_radius);
   end

   // deadband compare and result fields
   always_comb begin
      r2          = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      inside_dead = r2 < SUM_W'(dead_sq_ff);
      out_x_in    = inside_dead ? '0 : to_field(magx_ff, negx_ff);
      out_y_in    = inside_dead ? '0 : to_field(magy_ff, negy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         mvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         mvld_ff      <= vld_ff[FRAC_BITS];
         rsp_valid_ff <= mvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      dead_sq_ff <= dead_sq_in;
      if (adv) begin
         for (int k = 0; k <= FRAC_BITS; k++) begin
            lx_ff[k] <= lx_in[k];
            ly_ff[k] <= ly_in[k];
         end
         magx_ff  <= magx_in;
         magy_ff  <= magy_in;
         negx_ff  <= negx_in;
         negy_ff  <= negy_in;
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
      end
   end

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      vld_ff[FRAC_BITS] && adv |=> mvld_ff)
      else $error("last divide stage lost an item");

   a_mag_clamped: assert property (@(posedge clock) disable iff (reset)
      mvld_ff |-> magx_ff <= ONE_MAG && magy_ff <= ONE_MAG)
      else $error("magnitude above full scale");

   a_zero_not_neg: assert property (@(posedge clock) disable iff (reset)
      mvld_ff && (magx_ff == '0) |-> !negx_ff)
      else $error("zero magnitude marked negative");

endmodule

// ----- rtl/joystick_normalize_deadband.sv -----
// joystick_normalize_deadband: per-axis bound scaling, clamp, invert, radial deadband.
// Throughput: one request per cycle while the queue is not full (rsp_stall can fill it);
// the divide pipeline retires one quotient bit per stage.
// A 4-entry queue lets requests be taken while a finished result waits on rsp_stall.
// Reset (synchronous, active high) empties the queue and pipeline and loads register defaults.
module joystick_normalize_deadband
   import jnd_pkg::*;
#(
   parameter int AXIS_BITS = AXIS_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [AXIS_BITS-1:0] req_raw_x,
   input  logic signed [AXIS_BITS-1:0] req_raw_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_W-1:0]     rsp_out_x,
   output logic signed [OUT_W-1:0]     rsp_out_y,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   cfg_type  cfg;
   logic     q_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     q_valid;
   item_type q_item;

   jnd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jnd_front #(
      .AXIS_BITS (AXIS_BITS)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_raw_x (req_raw_x),
      .req_raw_y (req_raw_y),
      .cfg       (cfg),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   jnd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .rd_valid  (q_valid),
      .rd_item   (q_item)
   );

   jnd_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y)
   );

endmodule

// ----- verif/joystick_normalize_deadband_tb.sv -----
// Testbench for joystick_normalize_deadband: directed and random requests, with a
// self-contained prediction of the per-axis scaling, clamp, invert and radial deadband.
// Depends on rtl/jnd_pkg.sv (widths, register indexes, cfg_type) and the block itself.
module joystick_normalize_deadband_tb;
   import jnd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned ONE_Q = longint'(1) << FRAC_BITS_DEF;
   // index with no register behind it; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
   } norm_pair_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic signed [AXIS_BITS_DEF-1:0] req_raw_x;
   logic signed [AXIS_BITS_DEF-1:0] req_raw_y;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic signed [OUT_W-1:0]         rsp_out_x;
   logic signed [OUT_W-1:0]         rsp_out_y;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [CSR_IDX_W-1:0]            csr_index;
   logic [CSR_DATA_W-1:0]           csr_wdata;

   cfg_type        cfg_model;          // register contents as the block should hold them
   norm_pair_type  expected_norm[$];   // normalized samples still to come back
   int unsigned  send_gap_pct;
   int unsigned  rsp_stall_pct;
   int unsigned  hold_request;
   int unsigned  mismatch_count;
   int unsigned  samples_checked;
   int unsigned  settings_count;
   int unsigned  input_stall_cycles;

   joystick_normalize_deadband DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_raw_x (req_raw_x),
      .req_raw_y (req_raw_y),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("Timeout with %0d samples outstanding", expected_norm.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   // One axis: magnitude in Q1.14, sign returned through neg.
   function automatic longint unsigned scale_axis(
      input logic signed [AXIS_BITS_DEF-1:0] raw,
      input longint unsigned div_pos,
      input longint unsigned div_neg,
      input logic flip,
      output bit neg);
      longint unsigned mag, dv, q;
      bit below;
      below = (raw < 0);
      mag   = below ? -longint'(raw) : longint'(raw);
      dv    = below ? div_neg : div_pos;
      if (mag == 0) begin
         q = 0;
      end else if (dv == 0) begin
         q = ONE_Q;       // zero divisor saturates
      end else begin
         q = (mag << FRAC_BITS_DEF) / dv;
         if (q > ONE_Q) q = ONE_Q;
      end
      if (flip) below = !below;
      neg = (q != 0) && below;
      return q;
   endfunction

   function automatic norm_pair_type predict_norm(
      input logic signed [AXIS_BITS_DEF-1:0] rx,
      input logic signed [AXIS_BITS_DEF-1:0] ry);
      norm_pair_type res;
      bit nx, ny;
      longint unsigned mx, my, dr;
      mx = scale_axis(rx, cfg_model.upper_bound_x, cfg_model.lower_mag_x,
                      cfg_model.invert_x, nx);
      my = scale_axis(ry, cfg_model.upper_bound_y, cfg_model.lower_mag_y,
                      cfg_model.invert_y, ny);
      dr = cfg_model.dead_radius;
      // radial deadband, exact integer compare
      if (mx * mx + my * my < dr * dr) begin
         mx = 0;
         my = 0;
      end
      res.x = OUT_W'(nx ? -longint'(mx) : longint'(mx));
      res.y = OUT_W'(ny ? -longint'(my) : longint'(my));
      return res;
   endfunction

   function automatic cfg_type default_cfg();
      cfg_type c;
      c.upper_bound_x = 9'd511;
      c.lower_mag_x   = 10'd512;
      c.upper_bound_y = 9'd511;
      c.lower_mag_y   = 10'd512;
      c.invert_x      = 1'b0;
      c.invert_y      = 1'b0;
      c.dead_radius   = '0;
      return c;
   endfunction

   // ---------------------------------------------------------------- random choices

   function automatic int unsigned pick_bound(input int unsigned top,
                                              input int unsigned field_max);
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return top;
         3: return $urandom_range(top, field_max);
         default: return $urandom_range(1, top);
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.upper_bound_x = UB_W'(pick_bound(511, 511));
      c.lower_mag_x   = DIV_W'(pick_bound(512, 1023));
      c.upper_bound_y = UB_W'(pick_bound(511, 511));
      c.lower_mag_y   = DIV_W'(pick_bound(512, 1023));
      c.invert_x      = 1'($urandom);
      c.invert_y      = 1'($urandom);
      case ($urandom_range(0, 5))
         0: c.dead_radius = '0;
         1: c.dead_radius = DEAD_W'($urandom_range(0, 32767));
         2: c.dead_radius = DEAD_W'(23170);
         default: c.dead_radius = DEAD_W'($urandom_range(0, 16384));
      endcase
      return c;
   endfunction

   function automatic logic signed [AXIS_BITS_DEF-1:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(AXIS_BITS_DEF-1){1'b0}}};
         1: return {1'b0, {(AXIS_BITS_DEF-1){1'b1}}};
         2: return AXIS_BITS_DEF'(int'($urandom_range(0, 16)) - 8);
         3: return AXIS_BITS_DEF'(int'($urandom_range(0, 128)) - 64);
         default: return AXIS_BITS_DEF'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_sample(input logic signed [AXIS_BITS_DEF-1:0] rx,
                              input logic signed [AXIS_BITS_DEF-1:0] ry);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_x <= rx;
      req_raw_y <= ry;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_norm.push_back(predict_norm(rx, ry));
   endtask

   // csr_valid stays high; set_config lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value,
                            input int width, input bit junk);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'(value);
      if (junk) data = data | ((CSR_DATA_W'($urandom) >> width) << width);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_UPPER_BOUND_X: cfg_model.upper_bound_x = data[UB_W-1:0];
         REG_LOWER_MAG_X:   cfg_model.lower_mag_x   = data[DIV_W-1:0];
         REG_UPPER_BOUND_Y: cfg_model.upper_bound_y = data[UB_W-1:0];
         REG_LOWER_MAG_Y:   cfg_model.lower_mag_y   = data[DIV_W-1:0];
         REG_INVERT_X:      cfg_model.invert_x      = data[0];
         REG_INVERT_Y:      cfg_model.invert_y      = data[0];
         REG_DEAD_RADIUS:   cfg_model.dead_radius   = data[DEAD_W-1:0];
         default: ;
      endcase
   endtask

   // junk also fills the unused upper data bits and pokes the unmapped index
   task automatic set_config(input cfg_type c, input bit junk);
      write_reg(REG_UPPER_BOUND_X, c.upper_bound_x, UB_W, junk);
      write_reg(REG_LOWER_MAG_X, c.lower_mag_x, DIV_W, junk);
      write_reg(REG_UPPER_BOUND_Y, c.upper_bound_y, UB_W, junk);
      write_reg(REG_LOWER_MAG_Y, c.lower_mag_y, DIV_W, junk);
      write_reg(REG_INVERT_X, c.invert_x, 1, junk);
      write_reg(REG_INVERT_Y, c.invert_y, 1, junk);
      write_reg(REG_DEAD_RADIUS, c.dead_radius, DEAD_W, junk);
      if (junk) write_reg(REG_UNUSED, $urandom_range(0, 65535), 0, 1'b0);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // every request gives one result, so an empty queue means the block is idle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_norm.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, or a long hold-off counted here
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      norm_pair_type want;
      if (!reset && req_valid && req_stall) input_stall_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_norm.size() == 0) begin
            $display("%0t: unexpected result out_x %0d out_y %0d", $time, rsp_out_x,
                     rsp_out_y);
            mismatch_count++;
         end else begin
            want = expected_norm.pop_front();
            if (rsp_out_x !== want.x) begin
               $display("%0t: out_x mismatch, expected %0d, got %0d", $time, want.x,
                        rsp_out_x);
               mismatch_count++;
            end
            if (rsp_out_y !== want.y) begin
               $display("%0t: out_y mismatch, expected %0d, got %0d", $time, want.y,
                        rsp_out_y);
               mismatch_count++;
            end
         end
         samples_checked++;
      end
   end

   // ---------------------------------------------------------------- tests

   // register defaults written back explicitly, full-scale and tiny readings
   task automatic test_default_scaling();
      wait_drained();
      set_config(default_cfg(), 1'b0);
      send_sample(0, 0);
      send_sample(511, 511);
      send_sample(-512, -512);
      send_sample(511, -512);
      send_sample(-512, 511);
      send_sample(1, -1);
      send_sample(-1, 1);
      send_sample(256, -256);
   endtask

   // small bounds push the quotient past one; X is inverted
   task automatic test_clamp_and_invert();
      cfg_type c;
      wait_drained();
      c = default_cfg();
      c.upper_bound_x = 9'd1;
      c.lower_mag_x   = 10'd1;
      c.upper_bound_y = 9'd100;
      c.lower_mag_y   = 10'd1023;
      c.invert_x      = 1'b1;
      set_config(c, 1'b0);
      send_sample(1, 100);
      send_sample(-1, -512);
      send_sample(2, 511);
      send_sample(0, -1);
      send_sample(-512, 1);
   endtask

   // all bounds zero: any nonzero reading saturates; Y is inverted
   task automatic test_zero_divisor();
      cfg_type c;
      wait_drained();
      c = '0;
      c.invert_y = 1'b1;
      set_config(c, 1'b0);
      send_sample(1, -1);
      send_sample(-512, 511);
      send_sample(0, 0);
      send_sample(511, -1);
   endtask

   // deadband edges: radius exactly reached survives, just below is zeroed
   task automatic test_deadband();
      cfg_type c;
      wait_drained();
      c = default_cfg();
      c.dead_radius = DEAD_W'(16384);
      set_config(c, 1'b0);
      send_sample(511, 0);
      send_sample(510, 0);
      send_sample(0, -512);
      send_sample(300, 300);
      send_sample(0, 0);
      wait_drained();
      c.dead_radius = DEAD_W'(23170);
      set_config(c, 1'b0);
      send_sample(511, 511);
      send_sample(511, 510);
      wait_drained();
      c.dead_radius = DEAD_W'(32767);
      set_config(c, 1'b0);
      send_sample(511, -512);
   endtask

   // receiver holds off long enough for the queue and pipeline to fill
   task automatic test_output_holdoff();
      wait_drained();
      set_config(random_cfg(), 1'b0);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      hold_request  = 150;
      repeat (30) send_sample(pick_raw(), pick_raw());
   endtask

   task automatic test_random_stream(input int unsigned sender_pct,
                                     input int unsigned receiver_pct);
      send_gap_pct  = sender_pct;
      rsp_stall_pct = receiver_pct;
      repeat (5) begin
         wait_drained();
         set_config(random_cfg(), 1'b1);
         repeat (33) send_sample(pick_raw(), pick_raw());
      end
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_raw_x <= '0;
      req_raw_y <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      cfg_model          = default_cfg();
      send_gap_pct       = 15;
      rsp_stall_pct      = 68;
      hold_request       = 0;
      mismatch_count     = 0;
      samples_checked    = 0;
      settings_count     = 0;
      input_stall_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_scaling();
      test_clamp_and_invert();
      test_zero_divisor();
      test_deadband();
      test_random_stream(15, 68);
      test_random_stream(68, 15);
      test_random_stream(0, 0);
      test_output_holdoff();

      wait_drained();
      repeat (FRAC_BITS_DEF + 10) @(posedge clock);
      if (expected_norm.size() != 0) begin
         $display("%0t: %0d samples never returned", $time, expected_norm.size());
         mismatch_count++;
      end

      $display("Checked %0d samples under %0d register settings, with bounds, inversion,",
               samples_checked, settings_count);
      $display("deadband edges and %0d cycles of input backpressure exercised.",
               input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
